// ----- hdl/dns_response_answer_parser_assert.svh -----
// Assertion macros shared by the parser modules.
`ifndef DNS_RESPONSE_ANSWER_PARSER_ASSERT_SVH
`define DNS_RESPONSE_ANSWER_PARSER_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define DRAP_ASSERT_HOLD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The condition must never be true outside reset.
`define DRAP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- hdl/drap_pkg.sv -----
`timescale 1ns / 1ps

package drap_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_of_datagram;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] answer_number;
    logic [31:0] ipv4_address;
    logic [7:0]  name_byte;
    logic        end_of_record;
    logic        truncated;
  } out_item_t;

  typedef enum logic [2:0] {
    EV_A_RECORD    = 3'd0,
    EV_CNAME_BYTE  = 3'd1,
    EV_SKIPPED     = 3'd2,
    EV_ID_MISMATCH = 3'd3,
    EV_SERVER_ERR  = 3'd4,
    EV_NO_ANSWERS  = 3'd5
  } event_kind_t;

  typedef enum logic [4:0] {
    PH_HEADER   = 5'b00001,
    PH_QUESTION = 5'b00010,
    PH_RECHDR   = 5'b00100,
    PH_RDATA    = 5'b01000,
    PH_DONE     = 5'b10000
  } phase_t;

  localparam logic CFG_EXPECTED_ID   = 1'b0;
  localparam logic CFG_QUESTION_NAME = 1'b1;

  localparam logic [15:0] RESET_EXPECTED_ID   = 16'h0000;
  localparam logic [7:0]  RESET_QUESTION_NAME = 8'h01;

  localparam logic [15:0] TYPE_A     = 16'h0001;
  localparam logic [15:0] TYPE_CNAME = 16'h0005;
  localparam logic [7:0]  RCODE_MASK = 8'h0F;

  localparam logic [15:0] HDR_ID_HI     = 16'd0;
  localparam logic [15:0] HDR_ID_LO     = 16'd1;
  localparam logic [15:0] HDR_FLAGS_LO  = 16'd3;
  localparam logic [15:0] HDR_ANCOUNT_HI = 16'd6;
  localparam logic [15:0] HDR_ANCOUNT_LO = 16'd7;
  localparam logic [15:0] HDR_LAST      = 16'd11;

  localparam logic [16:0] QUESTION_TAIL = 17'd4;

  localparam logic [15:0] RR_TYPE_HI  = 16'd2;
  localparam logic [15:0] RR_TYPE_LO  = 16'd3;
  localparam logic [15:0] RR_RDLEN_HI = 16'd10;
  localparam logic [15:0] RR_HDR_LAST = 16'd11;

  localparam logic [15:0] ADDR_BYTES = 16'd4;
  localparam logic [15:0] POS_MAX    = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;

endpackage

// ----- hdl/drap_front.sv -----
`timescale 1ns / 1ps

module drap_front #(
  parameter int MAX_DATAGRAM_BYTES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                accept,
  input  drap_pkg::in_item_t  item,
  output logic                ev_valid,
  output drap_pkg::out_item_t ev
);
  import drap_pkg::*;

  localparam logic [15:0] MaxCount = 16'(MAX_DATAGRAM_BYTES);

  logic [15:0] expected_id;
  logic [7:0]  question_name_bytes;

  phase_t      phase, phase_next;
  logic [15:0] pos, pos_next;
  logic [7:0]  id_hi, id_hi_next;
  logic [15:0] answers_expected, answers_expected_next;
  logic [15:0] answers_done, answers_done_next;
  logic [15:0] record_type, record_type_next;
  logic [15:0] rdata_remaining, rdata_remaining_next;
  logic [31:0] address_shift, address_shift_next;
  logic [15:0] count, count_next;

  logic [7:0]  b;
  logic        ended;
  logic        finish;
  logic [15:0] done_inc;
  logic [15:0] rlen;
  logic [15:0] rem_dec;

  assign b = item.rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id         <= RESET_EXPECTED_ID;
      question_name_bytes <= RESET_QUESTION_NAME;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_EXPECTED_ID:   expected_id <= cfg_data;
        CFG_QUESTION_NAME: question_name_bytes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next            = phase;
    pos_next              = pos;
    id_hi_next            = id_hi;
    answers_expected_next = answers_expected;
    answers_done_next     = answers_done;
    record_type_next      = record_type;
    rdata_remaining_next  = rdata_remaining;
    address_shift_next    = address_shift;
    finish                = 1'b0;
    ev_valid              = 1'b0;
    ev                    = '0;
    ev.answer_number      = answers_done;
    rlen                  = {rdata_remaining[15:8], b};
    rem_dec               = rdata_remaining - 16'd1;

    count_next = (count != POS_MAX) ? count + 16'd1 : count;
    ended      = item.last_of_datagram || (count_next == MaxCount);

    case (phase)
      PH_HEADER: begin
        if (pos == HDR_ID_HI) begin
          id_hi_next = b;
        end else if (pos == HDR_ID_LO) begin
          if ({id_hi, b} != expected_id) begin
            ev_valid      = 1'b1;
            ev.event_kind = EV_ID_MISMATCH;
            ev.answer_number = '0;
            phase_next    = PH_DONE;
          end
        end else if (pos == HDR_FLAGS_LO) begin
          if ((b & RCODE_MASK) != 8'h00) begin
            ev_valid      = 1'b1;
            ev.event_kind = EV_SERVER_ERR;
            ev.answer_number = '0;
            phase_next    = PH_DONE;
          end
        end else if (pos == HDR_ANCOUNT_HI) begin
          answers_expected_next = {b, 8'h00};
        end else if (pos == HDR_ANCOUNT_LO) begin
          answers_expected_next = {answers_expected[15:8], b};
          if ({answers_expected[15:8], b} == 16'h0000) begin
            ev_valid      = 1'b1;
            ev.event_kind = EV_NO_ANSWERS;
            ev.answer_number = '0;
            phase_next    = PH_DONE;
          end
        end
        if (phase_next == PH_HEADER) begin
          if (pos >= HDR_LAST) begin
            phase_next = PH_QUESTION;
            pos_next   = '0;
          end else begin
            pos_next = pos + 16'd1;
          end
        end
      end
      PH_QUESTION: begin
        if ({1'b0, pos} + 17'd1 >= {9'b0, question_name_bytes} + QUESTION_TAIL) begin
          phase_next = PH_RECHDR;
          pos_next   = '0;
        end else begin
          pos_next = pos + 16'd1;
        end
      end
      PH_RECHDR: begin
        if (pos == RR_TYPE_HI) begin
          record_type_next = {b, 8'h00};
        end else if (pos == RR_TYPE_LO) begin
          record_type_next = {record_type[15:8], b};
        end else if (pos == RR_RDLEN_HI) begin
          rdata_remaining_next = {b, 8'h00};
        end
        if (pos < RR_HDR_LAST) begin
          pos_next = pos + 16'd1;
        end else begin
          rdata_remaining_next = rlen;
          address_shift_next   = '0;
          pos_next             = '0;
          if (record_type == TYPE_A || record_type == TYPE_CNAME) begin
            if (rlen == 16'h0000) begin
              ev_valid         = 1'b1;
              ev.event_kind    = (record_type == TYPE_A) ? EV_A_RECORD : EV_CNAME_BYTE;
              ev.end_of_record = 1'b1;
              finish           = 1'b1;
            end else begin
              phase_next = PH_RDATA;
            end
          end else begin
            ev_valid         = 1'b1;
            ev.event_kind    = EV_SKIPPED;
            ev.end_of_record = 1'b1;
            if (rlen == 16'h0000) begin
              finish = 1'b1;
            end else begin
              phase_next = PH_RDATA;
            end
          end
        end
      end
      PH_RDATA: begin
        rdata_remaining_next = rem_dec;
        if (record_type == TYPE_A) begin
          if (pos < ADDR_BYTES) begin
            address_shift_next = {address_shift[23:0], b};
          end
          if (rem_dec == 16'h0000) begin
            ev_valid         = 1'b1;
            ev.event_kind    = EV_A_RECORD;
            ev.ipv4_address  = address_shift_next;
            ev.end_of_record = 1'b1;
          end
        end else if (record_type == TYPE_CNAME) begin
          ev_valid         = 1'b1;
          ev.event_kind    = EV_CNAME_BYTE;
          ev.name_byte     = b;
          ev.end_of_record = (rem_dec == 16'h0000);
        end
        if (pos < POS_MAX) begin
          pos_next = pos + 16'd1;
        end
        if (rem_dec == 16'h0000) begin
          finish = 1'b1;
        end
      end
      default: ;
    endcase

    done_inc = answers_done + 16'd1;
    if (finish) begin
      answers_done_next = done_inc;
      if (done_inc == answers_expected) begin
        phase_next = PH_DONE;
      end else begin
        phase_next = PH_RECHDR;
        pos_next   = '0;
      end
    end

    if (ended) begin
      if (phase_next != PH_DONE) begin
        if (!ev_valid) begin
          ev_valid         = 1'b1;
          ev               = '0;
          ev.event_kind    = EV_SKIPPED;
          ev.answer_number = answers_done_next;
          ev.end_of_record = 1'b1;
        end
        ev.truncated = 1'b1;
      end
      if (item.last_of_datagram) begin
        phase_next            = PH_HEADER;
        pos_next              = '0;
        id_hi_next            = '0;
        answers_expected_next = '0;
        answers_done_next     = '0;
        record_type_next      = '0;
        rdata_remaining_next  = '0;
        address_shift_next    = '0;
        count_next            = '0;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (!accept) begin
      ev_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      pos              <= '0;
      id_hi            <= '0;
      answers_expected <= '0;
      answers_done     <= '0;
      record_type      <= '0;
      rdata_remaining  <= '0;
      address_shift    <= '0;
      count            <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      pos              <= pos_next;
      id_hi            <= id_hi_next;
      answers_expected <= answers_expected_next;
      answers_done     <= answers_done_next;
      record_type      <= record_type_next;
      rdata_remaining  <= rdata_remaining_next;
      address_shift    <= address_shift_next;
      count            <= count_next;
    end
  end

endmodule

// ----- hdl/drap_queue.sv -----
`timescale 1ns / 1ps

module drap_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  drap_pkg::out_item_t push_item,
  input  logic                pop,
  output logic                head_valid,
  output drap_pkg::out_item_t head_item,
  output logic                full
);
  import drap_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] DepthCount = CntW'(QUEUE_DEPTH);

  out_item_t         slots [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign full       = (count == DepthCount);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`include "dns_response_answer_parser_assert.svh"

  `DRAP_ASSERT_NEVER(a_push_full, clk, rst, push && full, "queue written while full")
  `DRAP_ASSERT_NEVER(a_pop_empty, clk, rst, pop && !head_valid, "queue read while empty")
  `DRAP_ASSERT_HOLD(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1), "queue count did not rise on a write")
  `DRAP_ASSERT_HOLD(a_count_bound, clk, rst, count <= DepthCount, "queue count beyond depth")

endmodule

// ----- hdl/drap_back.sv -----
`timescale 1ns / 1ps

module drap_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  drap_pkg::out_item_t head_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output drap_pkg::out_item_t out_item
);
  import drap_pkg::*;

  assign pop = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= head_item;
    end
  end

`include "dns_response_answer_parser_assert.svh"

  `DRAP_ASSERT_HOLD(a_load_valid, clk, rst, pop |=> out_valid, "loaded transaction not shown")
  `DRAP_ASSERT_HOLD(a_drain, clk, rst, (out_valid && !out_stall && !head_valid) |=> !out_valid, "transaction repeated after delivery")
  `DRAP_ASSERT_HOLD(a_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(out_item)), "stalled transaction changed")

endmodule

// ----- hdl/dns_response_answer_parser.sv -----
`timescale 1ns / 1ps

// Parses a DNS response datagram that arrives one byte per transaction and reports
// one event per byte at most: header failures, A record addresses, CNAME rdata bytes,
// skipped records and early ends of the datagram. A byte is taken every clock cycle
// while the output side keeps up; the parser walks the datagram with position and
// length counters, one byte at a time, and its events pass through a
// four-entry queue to a registered output, so in_stall rises only when that queue is
// full. An event enters the queue as its byte is accepted, then the output register.
// Configuration writes are taken at any time but must be made while the block is idle.

module dns_response_answer_parser #(
  parameter int MAX_DATAGRAM_BYTES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  drap_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output drap_pkg::out_item_t out_item
);
  import drap_pkg::*;

  logic      accept;
  logic      ev_valid;
  out_item_t ev;
  logic      pop;
  logic      head_valid;
  out_item_t head_item;
  logic      full;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  drap_front #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (in_item),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  drap_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_valid),
    .push_item (ev),
    .pop       (pop),
    .head_valid(head_valid),
    .head_item (head_item),
    .full      (full)
  );

  drap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- tb/dns_event_checker.sv -----
`timescale 1ns / 1ps

module dns_event_checker #(
  parameter int MAX_DATAGRAM_BYTES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  drap_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  drap_pkg::out_item_t out_item,
  output int                  error_count,
  output int                  events_waiting
);
  import drap_pkg::*;

  logic [15:0] want_id;
  logic [7:0]  qname_len;
  phase_t      phase;
  logic [15:0] pos;
  logic [15:0] rx_id;
  logic [15:0] an_expected;
  logic [15:0] an_done;
  logic [15:0] rr_type;
  logic [15:0] rd_left;
  logic [15:0] dg_count;
  logic [31:0] addr_acc;
  out_item_t   predicted_events[$];
  int          errors = 0;

  function automatic out_item_t make_event(event_kind_t kind, logic [31:0] addr,
                                           logic [7:0] nb, logic eor);
    out_item_t ev;
    ev.event_kind    = kind;
    ev.answer_number = an_done;
    ev.ipv4_address  = addr;
    ev.name_byte     = nb;
    ev.end_of_record = eor;
    ev.truncated     = 1'b0;
    return ev;
  endfunction

  task automatic clear_datagram();
    phase       = PH_HEADER;
    pos         = '0;
    rx_id       = '0;
    an_expected = '0;
    an_done     = '0;
    rr_type     = '0;
    rd_left     = '0;
    addr_acc    = '0;
    dg_count    = '0;
  endtask

  task automatic close_record();
    an_done = an_done + 16'd1;
    if (an_done == an_expected) begin
      phase = PH_DONE;
    end else begin
      phase = PH_RECHDR;
      pos   = '0;
    end
  endtask

  task automatic parse_response_byte(input logic [7:0] b, input logic last);
    out_item_t ev;
    logic      hit;
    logic      ended;
    hit = 1'b0;
    ev  = '0;
    if (dg_count != 16'hFFFF) dg_count = dg_count + 16'd1;
    ended = last || (int'(dg_count) == MAX_DATAGRAM_BYTES);
    case (phase)
      PH_HEADER: begin
        if (pos == 16'd0) begin
          rx_id = {b, 8'h00};
        end else if (pos == 16'd1) begin
          rx_id[7:0] = b;
          if (rx_id != want_id) begin
            ev    = make_event(EV_ID_MISMATCH, 32'h0, 8'h00, 1'b0);
            hit   = 1'b1;
            phase = PH_DONE;
          end
        end else if (pos == 16'd3) begin
          if ((b & RCODE_MASK) != 8'h00) begin
            ev    = make_event(EV_SERVER_ERR, 32'h0, 8'h00, 1'b0);
            hit   = 1'b1;
            phase = PH_DONE;
          end
        end else if (pos == 16'd6) begin
          an_expected = {b, 8'h00};
        end else if (pos == 16'd7) begin
          an_expected[7:0] = b;
          if (an_expected == 16'h0000) begin
            ev    = make_event(EV_NO_ANSWERS, 32'h0, 8'h00, 1'b0);
            hit   = 1'b1;
            phase = PH_DONE;
          end
        end
        if (phase == PH_HEADER) begin
          if (pos >= 16'd11) begin
            phase = PH_QUESTION;
            pos   = '0;
          end else begin
            pos = pos + 16'd1;
          end
        end
      end
      PH_QUESTION: begin
        if (int'(pos) + 1 >= int'(qname_len) + 4) begin
          phase = PH_RECHDR;
          pos   = '0;
        end else begin
          pos = pos + 16'd1;
        end
      end
      PH_RECHDR: begin
        if (pos == 16'd2) rr_type = {b, 8'h00};
        else if (pos == 16'd3) rr_type[7:0] = b;
        else if (pos == 16'd10) rd_left = {b, 8'h00};
        if (pos < 16'd11) begin
          pos = pos + 16'd1;
        end else begin
          rd_left[7:0] = b;
          addr_acc     = '0;
          pos          = '0;
          if (rr_type == TYPE_A) begin
            if (rd_left == 16'h0000) begin
              ev  = make_event(EV_A_RECORD, 32'h0, 8'h00, 1'b1);
              hit = 1'b1;
              close_record();
            end else begin
              phase = PH_RDATA;
            end
          end else if (rr_type == TYPE_CNAME) begin
            if (rd_left == 16'h0000) begin
              ev  = make_event(EV_CNAME_BYTE, 32'h0, 8'h00, 1'b1);
              hit = 1'b1;
              close_record();
            end else begin
              phase = PH_RDATA;
            end
          end else begin
            ev  = make_event(EV_SKIPPED, 32'h0, 8'h00, 1'b1);
            hit = 1'b1;
            if (rd_left == 16'h0000) close_record();
            else phase = PH_RDATA;
          end
        end
      end
      PH_RDATA: begin
        rd_left = rd_left - 16'd1;
        if (rr_type == TYPE_A) begin
          if (pos < 16'd4) addr_acc = {addr_acc[23:0], b};
          if (rd_left == 16'h0000) begin
            ev  = make_event(EV_A_RECORD, addr_acc, 8'h00, 1'b1);
            hit = 1'b1;
          end
        end else if (rr_type == TYPE_CNAME) begin
          ev  = make_event(EV_CNAME_BYTE, 32'h0, b, rd_left == 16'h0000);
          hit = 1'b1;
        end
        if (pos != 16'hFFFF) pos = pos + 16'd1;
        if (rd_left == 16'h0000) close_record();
      end
      default: begin
      end
    endcase
    if (ended) begin
      if (phase != PH_DONE) begin
        if (!hit) begin
          ev  = make_event(EV_SKIPPED, 32'h0, 8'h00, 1'b1);
          hit = 1'b1;
        end
        ev.truncated = 1'b1;
      end
      if (last) clear_datagram();
      else phase = PH_DONE;
    end
    if (hit) predicted_events.push_back(ev);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      want_id   = RESET_EXPECTED_ID;
      qname_len = RESET_QUESTION_NAME;
      clear_datagram();
      predicted_events.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_EXPECTED_ID) want_id = cfg_data;
        else qname_len = cfg_data[7:0];
      end
      if (out_valid && !out_stall) begin
        if (predicted_events.size() == 0) begin
          $error("event_kind: expected no transaction, got 0x%0h", out_item.event_kind);
          errors++;
        end else begin
          want = predicted_events.pop_front();
          check_field("event_kind", 32'(want.event_kind), 32'(out_item.event_kind));
          check_field("answer_number", 32'(want.answer_number), 32'(out_item.answer_number));
          check_field("ipv4_address", want.ipv4_address, out_item.ipv4_address);
          check_field("name_byte", 32'(want.name_byte), 32'(out_item.name_byte));
          check_field("end_of_record", 32'(want.end_of_record), 32'(out_item.end_of_record));
          check_field("truncated", 32'(want.truncated), 32'(out_item.truncated));
        end
      end
      if (in_valid && !in_stall) begin
        parse_response_byte(in_item.rx_byte, in_item.last_of_datagram);
      end
    end
    error_count    <= errors;
    events_waiting <= predicted_events.size();
  end

endmodule

// ----- tb/dns_response_answer_parser_tb.sv -----
`timescale 1ns / 1ps

module dns_response_answer_parser_tb;
  import drap_pkg::*;

  localparam int DGRAM_LIMIT = 1024;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  int          error_count;
  int          events_waiting;

  logic [7:0]  dgram[$];
  logic [15:0] cur_id = 16'h0000;
  int          bytes_sent = 0;
  bit          steady = 1'b0;
  int          stall_hold = 0;

  dns_response_answer_parser #(.MAX_DATAGRAM_BYTES(DGRAM_LIMIT)) uut (.*);

  dns_event_checker #(.MAX_DATAGRAM_BYTES(DGRAM_LIMIT)) u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    int pick;
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 12);
      end else if (pick < 90) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else if (pick < 96) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(60, 200);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(10, 30);
      end
    end
  end

  function automatic int pick_gap();
    int p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= '{rx_byte: b, last_of_datagram: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_datagram(input int cut_len);
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < cut_len; i++) begin
      send_byte(dgram[i], i == cut_len - 1);
    end
  endtask

  task automatic push_random(input int count);
    repeat (count) dgram.push_back(8'($urandom));
  endtask

  task automatic push_header(input logic [15:0] id, input logic [7:0] flags_lo,
                             input logic [15:0] ancount);
    dgram.push_back(id[15:8]);
    dgram.push_back(id[7:0]);
    push_random(1);
    dgram.push_back(flags_lo);
    push_random(2);
    dgram.push_back(ancount[15:8]);
    dgram.push_back(ancount[7:0]);
    push_random(4);
  endtask

  task automatic push_record(input logic [15:0] rtype, input logic [15:0] rdlen, input int body);
    if ($urandom_range(0, 3) != 0) begin
      dgram.push_back(8'hC0);
      dgram.push_back(8'h0C);
    end else begin
      push_random(2);
    end
    dgram.push_back(rtype[15:8]);
    dgram.push_back(rtype[7:0]);
    push_random(6);
    dgram.push_back(rdlen[15:8]);
    dgram.push_back(rdlen[7:0]);
    push_random(body);
  endtask

  task automatic push_random_record(output bit open_ended);
    logic [15:0] rtype;
    logic [15:0] rdlen;
    int          p;
    p = $urandom_range(0, 9);
    if (p < 4) begin
      rtype = TYPE_A;
      rdlen = ($urandom_range(0, 9) < 7) ? 16'd4 : 16'($urandom_range(0, 7));
    end else if (p < 7) begin
      rtype = TYPE_CNAME;
      rdlen = 16'($urandom_range(0, 10));
    end else begin
      rtype = 16'($urandom);
      rdlen = 16'($urandom_range(0, 8));
    end
    open_ended = ($urandom_range(0, 32) == 0);
    if (open_ended) begin
      rdlen = 16'($urandom_range(256, 65535));
      push_record(rtype, rdlen, $urandom_range(0, 20));
    end else begin
      push_record(rtype, rdlen, int'(rdlen));
    end
  endtask

  task automatic random_datagram(input int qlen);
    int          p;
    int          n;
    int          cut;
    logic [15:0] ancount;
    bit          open_ended;
    dgram.delete();
    p = $urandom_range(0, 99);
    if (p < 72) begin
      n = $urandom_range(1, 4);
      case ($urandom_range(0, 9))
        0: ancount = 16'(n + 1);
        1: ancount = 16'($urandom_range(1, 65535));
        default: ancount = 16'(n);
      endcase
      push_header(cur_id, {4'($urandom), 4'h0}, ancount);
      push_random(qlen + 4);
      for (int i = 0; i < n; i++) begin
        push_random_record(open_ended);
        if (open_ended) break;
      end
      if ($urandom_range(0, 6) == 0) push_random($urandom_range(1, 6));
    end else if (p < 92) begin
      if (p < 80) begin
        push_header(cur_id ^ (16'h0001 << $urandom_range(0, 15)), 8'($urandom), 16'($urandom));
      end else if (p < 86) begin
        push_header(cur_id, {4'($urandom), 4'($urandom_range(1, 15))},
                    16'($urandom_range(1, 65535)));
      end else begin
        push_header(cur_id, {4'($urandom), 4'h0}, 16'h0000);
      end
      push_random($urandom_range(0, 6));
    end else begin
      push_random($urandom_range(1, 16));
    end
    cut = dgram.size();
    if ($urandom_range(0, 6) == 0) cut = $urandom_range(1, dgram.size());
    send_datagram(cut);
  endtask

  task automatic long_datagram(input int qlen);
    bit open_ended;
    dgram.delete();
    push_header(cur_id, 8'h00, 16'd600);
    push_random(qlen + 4);
    while (dgram.size() < DGRAM_LIMIT + 16) push_random_record(open_ended);
    send_datagram(dgram.size());
  endtask

  task automatic drain_events();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_waiting != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_registers(input logic [15:0] id, input logic [7:0] qlen);
    cfg_index <= CFG_EXPECTED_ID;
    cfg_data  <= id;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_index <= CFG_QUESTION_NAME;
    cfg_data  <= {8'h00, qlen};
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_id = id;
  endtask

  task automatic run_phase(input logic [15:0] id, input logic [7:0] qlen, input int budget,
                           input bit with_long);
    drain_events();
    write_registers(id, qlen);
    bytes_sent = 0;
    if (with_long) long_datagram(int'(qlen));
    while (bytes_sent < budget) random_datagram(int'(qlen));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_registers(16'h0000, 8'd1);

    // Header failures, an end on the first byte and an all-ones identifier.
    dgram = '{8'h00, 8'h01, 8'hAA};
    send_datagram(3);
    dgram = '{8'h00, 8'h00, 8'h81, 8'h8F};
    send_datagram(4);
    dgram = '{8'h00, 8'h00, 8'h81, 8'h80, 8'h00, 8'h01, 8'h00, 8'h00};
    send_datagram(8);
    dgram = '{8'h00};
    send_datagram(1);
    dgram = '{8'hFF, 8'hFF};
    send_datagram(2);

    run_phase(16'hFFFF, 8'd0, 200, 1'b0);
    run_phase(16'($urandom), 8'd255, 200, 1'b0);
    run_phase(16'($urandom), 8'($urandom_range(1, 24)), 200, 1'b0);
    run_phase(16'($urandom), 8'd3, 0, 1'b1);
    drain_events();

    if (error_count == 0 && events_waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/drap_pkg.sv
hdl/drap_front.sv
hdl/drap_queue.sv
hdl/drap_back.sv
hdl/dns_response_answer_parser.sv
tb/dns_event_checker.sv
tb/dns_response_answer_parser_tb.sv
